>>> sv/lzsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared types and constants of the lzss decompressor: command codes passed
// from the token classifier to the copy engine, and the result item layout.
// ----------------------------------------------------------------------------
package lzsd_pkg;

    // command kinds moving through the queue between front and back
    typedef enum logic [1:0] {
        K_LIT  = 2'd0,
        K_COPY = 2'd1,
        K_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] lo;
        logic [7:0] hi;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       stream_last;
    } t_obyte;

    // token classifier states
    typedef enum logic [2:0] {
        PH_FLAG  = 3'b001,
        PH_TOKEN = 3'b010,
        PH_HIGH  = 3'b100
    } t_phase;

    // copy engine states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } t_bstate;

    localparam int Q_DEPTH     = 2;
    localparam int QAW         = $clog2(Q_DEPTH);
    localparam int OFIFO_DEPTH = 3;
    localparam int OFW         = $clog2(OFIFO_DEPTH);
    localparam int OCW         = $clog2(OFIFO_DEPTH + 1);

    localparam logic [8:0]  FLAG_STOP  = 9'h001;
    localparam logic [12:0] MATCH_SPAN = 13'h1000;
    localparam logic [4:0]  LEN_BIAS   = 5'd3;

endpackage

>>> sv/lzsd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzsd_in_if / lzsd_out_if
// Valid/ready channels carrying compressed input bytes and decompressed
// result bytes.
// ----------------------------------------------------------------------------
interface lzsd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface lzsd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;

    modport source (output valid, output out_byte, output run_last,
                    output stream_last, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input stream_last, output ready);
endinterface

>>> sv/lzsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzsd_front
// Token classifier: tracks flag bits, splits input bytes into literal, match
// and end-of-stream commands and pushes them into the command queue.
// ----------------------------------------------------------------------------
module lzsd_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lzsd_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output lzsd_pkg::t_cmd  o_cmd
);
    import lzsd_pkg::*;

    t_phase     r_phase, n_phase;
    logic [8:0] r_flags, n_flags;
    logic [7:0] r_lo,    n_lo;
    logic       acc;

    assign i_in.ready = !i_full;
    assign acc        = i_in.valid && !i_full;

    always_comb begin
        n_phase    = r_phase;
        n_flags    = r_flags;
        n_lo       = r_lo;
        o_push     = 1'b0;
        o_cmd.kind = K_END;
        o_cmd.lo   = i_in.in_byte;
        o_cmd.hi   = i_in.in_byte;
        o_cmd.last = i_in.in_last;
        if (acc) begin
            case (r_phase)
                PH_TOKEN: begin
                    n_flags = {1'b0, r_flags[8:1]};
                    if (r_flags[0]) begin
                        o_push     = 1'b1;
                        o_cmd.kind = K_LIT;
                        n_phase    = (n_flags <= FLAG_STOP) ? PH_FLAG : PH_TOKEN;
                    end else begin
                        n_lo    = i_in.in_byte;
                        n_phase = PH_HIGH;
                        // a match cut short still ends the stream
                        o_push  = i_in.in_last;
                    end
                end
                PH_HIGH: begin
                    o_push     = 1'b1;
                    o_cmd.kind = K_COPY;
                    o_cmd.lo   = r_lo;
                    n_phase    = (r_flags <= FLAG_STOP) ? PH_FLAG : PH_TOKEN;
                end
                default: begin
                    n_flags = {1'b1, i_in.in_byte};
                    n_phase = PH_TOKEN;
                    o_push  = i_in.in_last;
                end
            endcase
            if (i_in.in_last) begin
                n_phase = PH_FLAG;
                n_flags = FLAG_STOP;
                n_lo    = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_flags <= FLAG_STOP;
            r_lo    <= 8'h00;
        end else begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_lo    <= n_lo;
        end
    end

endmodule

>>> sv/lzsd_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzsd_cmd_queue
// Short command queue between the token classifier and the copy engine.
// ----------------------------------------------------------------------------
module lzsd_cmd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lzsd_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output logic            o_vld,
    output lzsd_pkg::t_cmd  o_cmd,
    input  logic            i_pop
);
    import lzsd_pkg::*;

    t_cmd           r_buf [Q_DEPTH];
    logic [QAW-1:0] r_head, r_tail;
    logic [QAW:0]   r_count;

    assign o_full = (r_count == (QAW+1)'(Q_DEPTH));
    assign o_vld  = (r_count != '0);
    assign o_cmd  = r_buf[r_head];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_tail] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= r_head + 1'b1;
            end
            r_count <= r_count + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

endmodule

>>> sv/lzsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzsd_back
// Copy engine: carries out literal, match and end commands against the history
// ring, one byte a cycle while the result buffer has room, and buffers result items.
// ----------------------------------------------------------------------------
module lzsd_back #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_vld,
    input  lzsd_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    lzsd_out_if.source      o_out
);
    import lzsd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int DW = AW + 1;
    localparam logic [DW-1:0] DEPTH_W   = DW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

    // issue stage
    t_bstate       r_state, n_state;
    logic [AW-1:0] r_wp, n_wp;
    logic          r_wrapped, n_wrapped;
    logic [AW-1:0] r_dist, n_dist;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_last, n_last;

    // write-back stage
    logic          r_w_vld;
    logic [AW-1:0] r_w_addr;
    logic          r_w_lit;
    logic [7:0]    r_w_lit_byte;
    logic          r_w_ok;
    logic          r_w_run;
    logic          r_w_strm;

    logic [7:0]    mem [HISTORY_DEPTH];
    logic [7:0]    r_rdata;
    logic          r_byp;
    logic [7:0]    r_byp_data;

    t_obyte        r_fifo [OFIFO_DEPTH];
    logic [OFW-1:0] r_head, r_tail;
    logic [OCW-1:0] r_count;

    logic          credit;
    logic [11:0]   code;
    logic [12:0]   dist13;
    logic [DW-1:0] dist_w;
    logic [AW-1:0] ld_dist;
    logic [DW-1:0] wp_w, dist_e;
    logic          behind;
    logic [AW-1:0] src;
    logic          src_ok;
    logic          issue, iss_lit, iss_run, iss_strm, clr;
    logic [7:0]    w_byte;
    logic          out_pop;

    assign credit = (OCW+1)'(r_count) + (OCW+1)'(r_w_vld) < (OCW+1)'(OFIFO_DEPTH);

    // distance 4096 folds to zero when the ring is exactly that deep
    assign code    = {i_cmd.hi[3:0], i_cmd.lo};
    assign dist13  = MATCH_SPAN - {1'b0, code};
    assign dist_w  = DW'(dist13);
    assign ld_dist = (dist_w == DEPTH_W) ? '0 : AW'(dist_w);

    assign wp_w   = DW'(r_wp);
    assign dist_e = DW'(r_dist);
    assign behind = (wp_w >= dist_e);
    assign src    = behind ? AW'(wp_w - dist_e) : AW'(wp_w + DEPTH_W - dist_e);
    // slots not yet written in this stream read as zero
    assign src_ok = r_wrapped || (behind && (r_dist != '0));

    always_comb begin
        n_state   = r_state;
        n_dist    = r_dist;
        n_cnt     = r_cnt;
        n_last    = r_last;
        o_cmd_pop = 1'b0;
        issue     = 1'b0;
        iss_lit   = 1'b0;
        iss_run   = 1'b0;
        iss_strm  = 1'b0;
        clr       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_vld) begin
                    case (i_cmd.kind)
                        K_LIT: begin
                            if (credit) begin
                                o_cmd_pop = 1'b1;
                                issue     = 1'b1;
                                iss_lit   = 1'b1;
                                iss_run   = 1'b1;
                                iss_strm  = i_cmd.last;
                            end
                        end
                        K_COPY: begin
                            o_cmd_pop = 1'b1;
                            n_dist    = ld_dist;
                            n_cnt     = 5'(i_cmd.hi[7:4]) + LEN_BIAS;
                            n_last    = i_cmd.last;
                            n_state   = ST_COPY;
                        end
                        K_END: begin
                            o_cmd_pop = 1'b1;
                            clr       = 1'b1;
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                if (credit) begin
                    issue    = 1'b1;
                    iss_run  = (r_cnt == 5'd1);
                    iss_strm = iss_run && r_last;
                    n_cnt    = r_cnt - 5'd1;
                    if (iss_run) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_wp      = r_wp;
        n_wrapped = r_wrapped;
        if (clr || (issue && iss_strm)) begin
            n_wp      = '0;
            n_wrapped = 1'b0;
        end else if (issue) begin
            n_wp      = (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
            n_wrapped = r_wrapped || (r_wp == LAST_SLOT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_wrapped <= 1'b0;
            r_cnt     <= '0;
            r_last    <= 1'b0;
            r_w_vld   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
            r_cnt     <= n_cnt;
            r_last    <= n_last;
            r_w_vld   <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist       <= n_dist;
        r_w_addr     <= r_wp;
        r_w_lit      <= iss_lit;
        r_w_lit_byte <= i_cmd.lo;
        r_w_ok       <= src_ok;
        r_w_run      <= iss_run;
        r_w_strm     <= iss_strm;
    end

    assign w_byte = r_w_lit ? r_w_lit_byte :
                    (r_w_ok ? (r_byp ? r_byp_data : r_rdata) : 8'h00);

    // history ring, read-first; a write to the slot being read is bypassed
    always_ff @(posedge i_clk) begin
        if (r_w_vld) begin
            mem[r_w_addr] <= w_byte;
        end
        r_rdata    <= mem[src];
        r_byp      <= r_w_vld && (r_w_addr == src);
        r_byp_data <= w_byte;
    end

    // result buffer
    assign out_pop           = o_out.valid && o_out.ready;
    assign o_out.valid       = (r_count != '0);
    assign o_out.out_byte    = r_fifo[r_head].out_byte;
    assign o_out.run_last    = r_fifo[r_head].run_last;
    assign o_out.stream_last = r_fifo[r_head].stream_last;

    always_ff @(posedge i_clk) begin
        if (r_w_vld) begin
            r_fifo[r_tail] <= '{out_byte: w_byte, run_last: r_w_run, stream_last: r_w_strm};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (r_w_vld) begin
                r_tail <= (r_tail == OFW'(OFIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (out_pop) begin
                r_head <= (r_head == OFW'(OFIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_count <= r_count + OCW'(r_w_vld) - OCW'(out_pop);
        end
    end

endmodule

>>> sv/lzss_decompressor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_decompressor_unit
// LZSS decompressor, 12-bit backward distance and 4-bit match length.
// ----------------------------------------------------------------------------
// i_in carries compressed bytes (flag, literal and match token bytes) with
// in_last on the final byte of a stream; o_out carries one decompressed byte
// per item, with run_last on the last byte caused by an input item and
// stream_last on the last byte caused by the input marked in_last.
// A classifier takes one input byte per cycle while the queue has room and feeds
// a two-entry command queue; the copy engine behind it writes one byte per cycle
// into the history ring while the result buffer has room. A literal is written
// straight away; a match is first loaded and then copies 3 to 18 bytes. Each
// command passes the command queue, and each byte the write-back stage and
// the result buffer, on its way to o_out.
// Copy reads go through the history memory read port with a registered read;
// back-to-back overlapping reads use a write bypass.
// Reset, and the end of every stream, empties the ring logically through the
// write pointer and a wrap flag: no clearing pass, the block is ready at once.
// When the sink stalls, a three-entry result buffer fills, the copy engine
// stops, then the command queue fills and i_in.ready drops.
// ----------------------------------------------------------------------------
module lzss_decompressor_unit #(
    parameter int HISTORY_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzsd_in_if.sink     i_in,
    lzsd_out_if.source  o_out
);
    import lzsd_pkg::*;

    logic q_push, q_full, q_vld, q_pop;
    t_cmd q_in, q_out;

    lzsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    lzsd_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    lzsd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (q_out),
        .o_cmd_pop (q_pop),
        .o_out     (o_out)
    );

endmodule

>>> sv/lzsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzsd_checker
// Port-level checks on the decompressor result channel.
// ----------------------------------------------------------------------------
module lzsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_run_last,
    input logic       i_stream_last
);

    // a waiting item stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item withdrawn while stalled");

    a_payload_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_byte) && $stable(i_run_last) && $stable(i_stream_last))
        else $error("result item changed while stalled");

    // end of stream always closes an input item's run
    a_stream_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stream_last |-> i_run_last)
        else $error("stream_last without run_last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

endmodule

bind lzss_decompressor_unit lzsd_checker u_lzsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_run_last    (o_out.run_last),
    .i_stream_last (o_out.stream_last)
);
